>>> rtl/hcenc_pkg.sv
package hcenc_pkg;

   // Fixed geometry of the key matrix and the letter alphabet.
   localparam int KEY_DIM = 4;
   localparam int ROW_W   = $clog2(KEY_DIM);
   localparam int POS_W   = 5;
   localparam int LEN_W   = 3;
   localparam int KEY_W   = KEY_DIM * POS_W;
   localparam int SUM_W   = 12;
   localparam int PROD_W  = 24;
   localparam int QUO_W   = 7;

   localparam logic [POS_W-1:0] PAD_POSITION = 5'd23;
   localparam logic [7:0]       ASCII_A      = 8'd65;
   localparam logic [7:0]       ASCII_Z      = 8'd90;
   localparam logic [6:0]       LETTER_A     = 7'd65;
   localparam logic [SUM_W-1:0] RADIX        = 12'd26;
   // floor(x * RECIP / 2^16) equals floor(x / 26) for every dot product sum.
   localparam logic [SUM_W-1:0] RECIP        = 12'd2521;
   localparam int               RECIP_SHIFT  = 16;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW3 = 3'd4;
   localparam logic [LEN_W-1:0]     SIZE_RESET   = 3'd2;

   typedef logic [KEY_DIM-1:0][POS_W-1:0] key_row_type;
   typedef key_row_type [KEY_DIM-1:0]     key_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] cipher_byte;
      logic       group_done;
      logic       message_done;
   } rsp_type;

   // One complete group, padded, ready for the matrix product.
   typedef struct packed {
      key_row_type      vec;
      logic [LEN_W-1:0] len;
      logic             last;
   } group_type;

   // One dot product on its way to the modulo stage.
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             group_done;
      logic             message_done;
   } dot_type;

endpackage

>>> rtl/hcenc_gather.sv
module hcenc_gather #(
   parameter int MAX_SIZE = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  hcenc_pkg::req_type    req_data,
   input  logic [2:0]            size_in_use,
   output logic                  push,
   output hcenc_pkg::group_type  group
);
   import hcenc_pkg::*;

   localparam int LIMIT = (MAX_SIZE < KEY_DIM) ? MAX_SIZE : KEY_DIM;

   logic [POS_W-1:0] store_ff [MAX_SIZE];
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0] prev_ff, prev_in;

   key_row_type      store_view;
   logic             is_letter;
   logic [POS_W-1:0] pos;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] fill_next;
   logic             emit;

   for (genvar k = 0; k < KEY_DIM; k++) begin : g_view
      if (k < MAX_SIZE) begin : g_kept
         assign store_view[k] = store_ff[k];
      end else begin : g_absent
         assign store_view[k] = PAD_POSITION;
      end
   end

   always_comb begin
      is_letter = (req_data.text_byte >= ASCII_A) && (req_data.text_byte <= ASCII_Z);
      pos       = is_letter ? POS_W'(req_data.text_byte - ASCII_A) : prev_ff;

      if (size_in_use == 3'd0) begin
         len = 3'd1;
      end else if (size_in_use > LEN_W'(LIMIT)) begin
         len = LEN_W'(LIMIT);
      end else begin
         len = size_in_use;
      end

      fill_next = fill_ff + 3'd1;
      emit      = req_data.final_byte || (fill_next >= len);

      // Slots already held, then the incoming letter, then padding.
      for (int k = 0; k < KEY_DIM; k++) begin
         if (LEN_W'(k) == fill_ff) begin
            group.vec[k] = pos;
         end else if (LEN_W'(k) < fill_ff) begin
            group.vec[k] = store_view[k];
         end else begin
            group.vec[k] = PAD_POSITION;
         end
      end
      group.len  = len;
      group.last = req_data.final_byte;
      push       = accept && emit;

      prev_in = (accept && is_letter) ? pos : prev_ff;
      if (accept) begin
         fill_in = emit ? '0 : fill_next;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         prev_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_SIZE; j++) begin
         if (accept && (fill_ff == LEN_W'(j))) begin
            store_ff[j] <= pos;
         end
      end
   end

endmodule

>>> rtl/hcenc_group_fifo.sv
module hcenc_group_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hcenc_pkg::group_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output hcenc_pkg::group_type head
);
   import hcenc_pkg::*;

   group_type  entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head      = entry_ff[rd_ff];
      wr_in     = push ? ~wr_ff : wr_ff;
      rd_in     = pop ? ~rd_ff : rd_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("group pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("group popped from an empty queue");
`endif

endmodule

>>> rtl/hcenc_emitter.sv
module hcenc_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 group_valid,
   input  hcenc_pkg::group_type group,
   input  hcenc_pkg::key_type   key,
   input  logic                 dot_ready,
   output logic                 pop,
   output logic                 dot_valid,
   output hcenc_pkg::dot_type   dot_data
);
   import hcenc_pkg::*;

   logic [ROW_W-1:0] row_ff, row_in;
   logic             valid_ff, valid_in;
   dot_type          data_ff, data_in;

   key_row_type      key_row;
   logic             stage_free;
   logic             issue;
   logic             last_row;

   always_comb begin
      key_row    = key[row_ff];
      stage_free = !valid_ff || dot_ready;
      issue      = group_valid && stage_free;
      last_row   = (LEN_W'(row_ff) + 3'd1) == group.len;
      pop        = issue && last_row;

      data_in.sum = '0;
      for (int k = 0; k < KEY_DIM; k++) begin
         if (LEN_W'(k) < group.len) begin
            data_in.sum = data_in.sum + SUM_W'(key_row[k]) * SUM_W'(group.vec[k]);
         end
      end
      data_in.group_done   = last_row;
      data_in.message_done = last_row && group.last;

      valid_in = stage_free ? issue : valid_ff;
      if (issue) begin
         row_in = last_row ? '0 : row_ff + 1'b1;
      end else begin
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         data_ff <= data_in;
      end
   end

   assign dot_valid = valid_ff;
   assign dot_data  = data_ff;

`ifndef SYNTH
   a_row_in_group: assert property (@(posedge clock) disable iff (reset)
      group_valid |-> (LEN_W'(row_ff) < group.len))
      else $error("row counter ran past the group length");
`endif

endmodule

>>> rtl/hcenc_reduce.sv
module hcenc_reduce (
   input  logic               clock,
   input  logic               reset,
   input  logic               dot_valid,
   input  hcenc_pkg::dot_type dot_data,
   output logic               dot_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output hcenc_pkg::rsp_type rsp_data
);
   import hcenc_pkg::*;

   logic             b_valid_ff, b_valid_in;
   dot_type          b_data_ff;
   logic [QUO_W-1:0] b_quo_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;

   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  rem;
   logic              out_free;
   logic              b_free;

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      b_free    = !b_valid_ff || out_free;
      dot_ready = b_free;

      prod = PROD_W'(dot_data.sum) * PROD_W'(RECIP);
      rem  = b_data_ff.sum - SUM_W'(b_quo_ff) * RADIX;

      out_data_in.cipher_byte  = LETTER_A + 7'(rem[POS_W-1:0]);
      out_data_in.group_done   = b_data_ff.group_done;
      out_data_in.message_done = b_data_ff.message_done;

      b_valid_in   = b_free ? dot_valid : b_valid_ff;
      out_valid_in = out_free ? b_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_free && dot_valid) begin
         b_data_ff <= dot_data;
         b_quo_ff  <= prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
      end
      if (out_free && b_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> rtl/hill_cipher_encrypt.sv
// Hill cipher encryptor, modulo 26. Plaintext arrives one byte per beat on
// the req_ channel; an uppercase letter gives its alphabet position and any
// other byte repeats the last letter position seen (A before any letter).
// Positions gather into groups of n = size_in_use letters, held to 1..4 and
// to MAX_SIZE. Each full group, or a short group padded with X when the beat
// carries final_byte, leaves as n cipher letters on the rsp_ channel, one per
// beat, the last of a group marked by group_done and the last of a message by
// message_done. Unless stalled, the block takes one byte per cycle and
// delivers one letter per cycle, so a stream of whole groups runs at one byte
// per cycle with emission of a group overlapping collection of the next. The
// first letter of a group passes the group queue, the emitter's register and
// the reduce quotient and output registers; the sequencer uses a key row per
// letter. A two-entry group queue sits between collection and emission,
// and req_stall rises while it is full, which happens when short padded
// groups produce more letters than bytes or when rsp_stall holds the output.
// The key rows and size are set through the csr_ port, which is always ready
// and must only be written while no letters are pending.
module hill_cipher_encrypt #(
   parameter int MAX_SIZE = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  hcenc_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hcenc_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hcenc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hcenc_pkg::KEY_W-1:0]         csr_data
);
   import hcenc_pkg::*;

   // Configuration registers.
   logic [LEN_W-1:0] size_ff;
   key_type          key_ff;

   // Beat bookkeeping between the stages.
   logic      accept;
   logic      push;
   group_type push_group;
   logic      pop;
   logic      queue_full;
   logic      queue_valid;
   group_type head_group;
   logic      dot_valid;
   logic      dot_ready;
   dot_type   dot_data;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // Writes to indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         key_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SIZE:     size_ff   <= csr_data[LEN_W-1:0];
            CSR_KEY_ROW0: key_ff[0] <= csr_data;
            CSR_KEY_ROW1: key_ff[1] <= csr_data;
            CSR_KEY_ROW2: key_ff[2] <= csr_data;
            CSR_KEY_ROW3: key_ff[3] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Letter positions and the partially filled group.
   hcenc_gather #(
      .MAX_SIZE (MAX_SIZE)
   ) u_gather (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .size_in_use (size_ff),
      .push        (push),
      .group       (push_group)
   );

   // Completed groups wait here while the previous one is emitted.
   hcenc_group_fifo u_group_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_group),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_valid),
      .head      (head_group)
   );

   // Walks the key rows and forms one dot product per cycle while dot_ready holds.
   hcenc_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .group_valid (queue_valid),
      .group       (head_group),
      .key         (key_ff),
      .dot_ready   (dot_ready),
      .pop         (pop),
      .dot_valid   (dot_valid),
      .dot_data    (dot_data)
   );

   // Reduces each sum modulo 26 and holds the letter for the output beat.
   hcenc_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .dot_valid (dot_valid),
      .dot_data  (dot_data),
      .dot_ready (dot_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
